FILE: hdl/msbr_pkg.sv
// Shared types and constants for the MSB-first bit field reader.
// Depends on nothing; every other file imports it.
`default_nettype none

package msbr_pkg;

  // Default sizes; the top level hands them down as parameters.
  localparam int BUF_BYTES_DEF      = 4096;
  localparam int MAX_FIELD_BITS_DEF = 31;

  // Largest cursor value, and the byte span that a 12-bit load address reaches.
  localparam int CURSOR_MAX = 32767;
  localparam int ADDR_SPAN  = 4096;

  // Request modes.
  localparam logic [2:0] MODE_LOAD  = 3'd0;
  localparam logic [2:0] MODE_SETPOS = 3'd1;
  localparam logic [2:0] MODE_UBITS = 3'd2;
  localparam logic [2:0] MODE_SBITS = 3'd3;
  localparam logic [2:0] MODE_UI8   = 3'd4;
  localparam logic [2:0] MODE_UI16  = 3'd5;
  localparam logic [2:0] MODE_SI16  = 3'd6;

  // Eight consecutive bytes, lowest address in the top byte.
  typedef logic [63:0] msbr_window_t;

  // What the extraction stage needs to know about the request in flight.
  typedef struct packed {
    logic [2:0] mode;
    logic [4:0] cnt;  // saturated field length for the bit modes
    logic [4:0] off;  // bit offset of the field inside the window
    logic       oor;  // read refused
  } msbr_req_t;

endpackage

`default_nettype wire

FILE: hdl/msbr_store.sv
// Byte store of the bit field reader: two 32-bit word banks (even and odd words).
// Depends on msbr_pkg. Byte writes, and one registered read of two adjacent words.
`default_nettype none

module msbr_store
  import msbr_pkg::*;
#(
  parameter int BUF_BYTES = BUF_BYTES_DEF
) (
  input  wire logic         clk,
  input  wire logic         wr_en,
  input  wire logic [11:0]  wr_addr,
  input  wire logic [7:0]   wr_data,
  input  wire logic         rd_en,
  input  wire logic [10:0]  rd_word,
  output msbr_window_t      window
);

  localparam int STORE_BYTES = (BUF_BYTES < ADDR_SPAN) ? BUF_BYTES : ADDR_SPAN;
  localparam int WORDS       = (STORE_BYTES + 3) / 4;
  localparam int ROWS        = (WORDS + 1) / 2;
  localparam int ROW_W       = $clog2(ROWS);

  logic [31:0] even_mem [ROWS];
  logic [31:0] odd_mem  [ROWS];

  logic [31:0] even_q;
  logic [31:0] odd_q;
  logic        par_q;

  logic [11:0]      even_row_full;
  logic [11:0]      odd_row_full;
  logic [ROW_W-1:0] even_row;
  logic [ROW_W-1:0] odd_row;
  logic [ROW_W-1:0] wr_row;
  logic [31:0]      first_word;
  logic [31:0]      second_word;

  // Word w and word w+1 always sit in different banks.
  assign even_row_full = (12'(rd_word) + 12'd1) >> 1;
  assign odd_row_full  = 12'(rd_word) >> 1;
  assign even_row = (even_row_full < 12'(ROWS)) ? ROW_W'(even_row_full) : '0;
  assign odd_row  = (odd_row_full  < 12'(ROWS)) ? ROW_W'(odd_row_full)  : '0;
  assign wr_row   = ROW_W'(wr_addr >> 3);

  always_ff @(posedge clk) begin
    if (wr_en && !wr_addr[2]) begin
      even_mem[wr_row][{wr_addr[1:0], 3'b000} +: 8] <= wr_data;
    end
    if (wr_en && wr_addr[2]) begin
      odd_mem[wr_row][{wr_addr[1:0], 3'b000} +: 8] <= wr_data;
    end
    if (rd_en) begin
      even_q <= even_mem[even_row];
      odd_q  <= odd_mem[odd_row];
      par_q  <= rd_word[0];
    end
  end

  assign first_word  = par_q ? odd_q  : even_q;
  assign second_word = par_q ? even_q : odd_q;

  // Byte lane 0 holds the lowest address, which comes first in the bit stream.
  assign window = {first_word[7:0],   first_word[15:8],  first_word[23:16],  first_word[31:24],
                   second_word[7:0],  second_word[15:8], second_word[23:16], second_word[31:24]};

endmodule

`default_nettype wire

FILE: hdl/msbr_extract.sv
// Field extraction of the bit field reader: shifts the byte window and formats
// the result. Depends on msbr_pkg.
`default_nettype none

module msbr_extract
  import msbr_pkg::*;
(
  input  msbr_window_t       window,
  input  msbr_req_t          req,
  output logic signed [31:0] value
);

  msbr_window_t       shifted;
  logic [31:0]        top;
  logic [5:0]         sh;
  logic [31:0]        ubits;
  logic signed [31:0] sbits;

  assign shifted = window << req.off;
  assign top     = shifted[63:32];
  assign sh      = 6'd32 - {1'b0, req.cnt};
  assign ubits   = top >> sh;
  assign sbits   = (req.cnt == 5'd0) ? 32'sd0 : ($signed(top) >>> sh);

  always_comb begin
    value = '0;
    if (!req.oor) begin
      case (req.mode)
        MODE_UBITS: value = $signed(ubits);
        MODE_SBITS: value = sbits;
        MODE_UI8:   value = $signed({24'd0, top[31:24]});
        MODE_UI16:  value = $signed({16'd0, top[23:16], top[31:24]});
        MODE_SI16:  value = $signed({{16{top[23]}}, top[23:16], top[31:24]});
        default:    value = '0;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: hdl/msb_first_bit_field_reader.sv
// MSB-first bit field reader: a byte store with a bit cursor.
// One request channel and one result channel, both valid/ready. Each request
// (load byte, set cursor, read bits, read aligned ui8/ui16/si16) produces
// exactly one result carrying value, the cursor after the request, and
// out_of_range.
// Sequence: a request is taken in the idle cycle; the cursor is updated and the
// two bank reads are issued at that edge. In the busy state the registered read
// data is shifted into place and the result is written to the output register
// once that register is free. No new request is taken until that result is
// written; the limit is the registered read of the word banks.
// When the receiver stalls, the block still takes the next request as long as
// the previous result sits in the output register; it only waits in its busy
// cycle until that register is free.
// Reset clears the cursor, the handshake and the state machine. The byte store
// is not cleared; reading a byte that was never loaded gives an undefined
// field. No clearing pass is needed, so requests are taken right after reset.
// Depends on msbr_pkg, msbr_store and msbr_extract.
`default_nettype none

module msb_first_bit_field_reader
  import msbr_pkg::*;
#(
  parameter int BUF_BYTES      = BUF_BYTES_DEF,
  parameter int MAX_FIELD_BITS = MAX_FIELD_BITS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [2:0]    mode,
  input  wire logic [11:0]   byte_addr,
  input  wire logic [7:0]    byte_value,
  input  wire logic [4:0]    bit_count,
  input  wire logic [14:0]   new_position,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic signed [31:0] value,
  output logic [14:0]        position,
  output logic               out_of_range
);

  // The last bit position a read may reach.
  localparam int END_LIMIT = (BUF_BYTES * 8 < CURSOR_MAX) ? BUF_BYTES * 8 : CURSOR_MAX;

  typedef enum logic {S_IDLE, S_BUSY} state_t;

  state_t      state;
  logic [14:0] cursor;
  msbr_req_t   req;

  logic               accept;
  logic               is_read;
  logic               is_bits;
  logic [4:0]         cnt_sat;
  logic [15:0]        aligned;
  logic [15:0]        start;
  logic [5:0]         len;
  logic [16:0]        stop;
  logic               oor_next;
  logic               wr_en;
  msbr_window_t       window;
  logic signed [31:0] field;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  assign is_bits = (mode == MODE_UBITS) || (mode == MODE_SBITS);
  assign is_read = is_bits || (mode == MODE_UI8) || (mode == MODE_UI16) ||
                   (mode == MODE_SI16);

  // Bit reads start at the cursor; the byte reads first round it up to a byte.
  assign cnt_sat = (32'(bit_count) > MAX_FIELD_BITS) ? 5'(MAX_FIELD_BITS) : bit_count;
  assign aligned = (16'(cursor) + 16'd7) & ~16'd7;
  assign start   = is_bits ? 16'(cursor) : aligned;

  always_comb begin
    unique case (mode) inside
      MODE_UBITS, MODE_SBITS: len = {1'b0, cnt_sat};
      MODE_UI8:               len = 6'd8;
      default:                len = 6'd16;
    endcase
  end

  assign stop     = 17'(start) + 17'(len);
  assign oor_next = is_read && (stop > 17'(END_LIMIT));

  // Loads beyond the buffer are dropped.
  assign wr_en = accept && (mode == MODE_LOAD) && (32'(byte_addr) < BUF_BYTES);

  // A load writes at its accept edge and a read is issued at a later accept
  // edge, so the store never sees a read and a write of the same request.
  msbr_store #(
    .BUF_BYTES (BUF_BYTES)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (byte_addr),
    .wr_data (byte_value),
    .rd_en   (accept && is_read),
    .rd_word (start[15:5]),
    .window  (window)
  );

  msbr_extract u_extract (
    .window (window),
    .req    (req),
    .value  (field)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cursor    <= '0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (out_ready) begin
            out_valid <= 1'b0;
          end
          if (accept) begin
            req.mode <= mode;
            req.cnt  <= cnt_sat;
            req.off  <= start[4:0];
            req.oor  <= oor_next;
            if (mode == MODE_SETPOS) begin
              cursor <= new_position;
            end else if (is_read && !oor_next) begin
              cursor <= stop[14:0];
            end
            state <= S_BUSY;
          end
        end
        S_BUSY: begin
          // Wait here only while the previous result is still unclaimed.
          if (!out_valid || out_ready) begin
            out_valid    <= 1'b1;
            value        <= field;
            position     <= cursor;
            out_of_range <= req.oor;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: hdl/msbr_checker.sv
// Port-level checks for the bit field reader, and the bind that attaches them.
// Depends on msbr_pkg and the top level msb_first_bit_field_reader.
`default_nettype none

module msbr_checker
  import msbr_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic signed [31:0] value,
  input wire logic [14:0]        position,
  input wire logic               out_of_range
);

  // A stalled result keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(value) && $stable(position) &&
                                $stable(out_of_range))
    else $error("result changed while stalled");

  // One request at a time: the cycle after an accept is the busy cycle.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

  // The busy cycle ends with a result whenever the output register is free.
  a_busy_finishes: assert property (@(posedge clk) disable iff (rst)
    !in_ready && (!out_valid || out_ready) |=> in_ready && out_valid)
    else $error("busy cycle did not produce a result");

  // A refused read never carries data.
  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_of_range |-> value == 32'sd0)
    else $error("refused read carries a value");

endmodule

bind msb_first_bit_field_reader msbr_checker u_msbr_checker (.*);

`default_nettype wire

FILE: bench/tb_top.sv
// Self-checking bench for msb_first_bit_field_reader: drives requests through the
// valid/ready handshake and predicts each result from a model of the byte store and cursor.
// Depends on msbr_pkg and the block's top level; nothing else.

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import msbr_pkg::*;

  // The one mode the block leaves unused: it must answer with a zero value and change nothing.
  localparam logic [2:0] MODE_SPARE = 3'd7;

  // Last bit position a read may end on.
  localparam int END_BITS = (BUF_BYTES_DEF * 8 < CURSOR_MAX) ? BUF_BYTES_DEF * 8 : CURSOR_MAX;

  localparam int RANDOM_REQUESTS = 1350;
  localparam int TAIL_CYCLES     = 20;
  localparam int CYCLE_LIMIT     = 1_000_000;

  typedef struct {
    logic signed [31:0] value;
    logic [14:0]        position;
    logic               out_of_range;
  } field_result_t;

  // Tracks the byte store, which entries were ever loaded, and the bit cursor, and keeps
  // the results that accepted requests still owe in arrival order.
  class field_reader_sb_t;
    logic [7:0]    store [BUF_BYTES_DEF];
    bit            loaded [BUF_BYTES_DEF];
    bit [14:0]     cursor;
    field_result_t pending_fields [$];
    int            fail_count;

    // Gathers len bits starting at bit first; bit 7 of the lower byte comes out first.
    function bit [31:0] read_msb_first(int unsigned first, int unsigned len);
      bit [31:0]   acc;
      int unsigned p;
      acc = '0;
      for (int unsigned i = 0; i < len; i++) begin
        p   = first + i;
        acc = {acc[30:0], store[p >> 3][7 - (p & 7)]};
      end
      return acc;
    endfunction

    function void note_request(bit [2:0] m, bit [11:0] addr, bit [7:0] data,
                               bit [4:0] cnt, bit [14:0] npos);
      field_result_t r;
      int unsigned   start;
      int unsigned   len;
      bit [31:0]     v;
      bit [31:0]     mask;
      v              = '0;
      r.out_of_range = 1'b0;
      case (m) inside
        MODE_LOAD: begin
          store[addr]  = data;
          loaded[addr] = 1'b1;
        end
        MODE_SETPOS: begin
          cursor = npos;
        end
        MODE_UBITS, MODE_SBITS, MODE_UI8, MODE_UI16, MODE_SI16: begin
          start = cursor;
          if (m == MODE_UBITS || m == MODE_SBITS) begin
            len = (cnt > MAX_FIELD_BITS_DEF) ? MAX_FIELD_BITS_DEF : cnt;
          end else begin
            // Aligned reads start at the next byte boundary.
            start = (start + 7) & ~32'd7;
            len   = (m == MODE_UI8) ? 8 : 16;
          end
          if (start + len > END_BITS) begin
            // Refused: the cursor stays put, alignment included.
            r.out_of_range = 1'b1;
          end else begin
            v = read_msb_first(start, len);
            if (m == MODE_SBITS && len != 0) begin
              mask = (32'd1 << len) - 32'd1;
              if (v[len - 1]) v = v | ~mask;
            end
            // The 16-bit values are little-endian: the first byte is the low one.
            if (m == MODE_UI16 || m == MODE_SI16) v = {16'd0, v[7:0], v[15:8]};
            if (m == MODE_SI16) v = {{16{v[15]}}, v[15:0]};
            cursor = 15'(start + len);
          end
        end
        default: begin
        end
      endcase
      r.value    = v;
      r.position = cursor;
      pending_fields.insert(pending_fields.size(), r);
    endfunction

    function void check_result(logic signed [31:0] val, logic [14:0] pos, logic oor);
      field_result_t e;
      if (pending_fields.size() == 0) begin
        $error("result with no request outstanding: value %0d position %0d", val, pos);
        fail_count++;
        return;
      end
      e = pending_fields.pop_front();
      if (val !== e.value) begin
        $error("value: expected %0d, got %0d", e.value, val);
        fail_count++;
      end
      if (pos !== e.position) begin
        $error("position: expected %0d, got %0d", e.position, pos);
        fail_count++;
      end
      if (oor !== e.out_of_range) begin
        $error("out_of_range: expected %0b, got %0b", e.out_of_range, oor);
        fail_count++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic [2:0]         mode;
  logic [11:0]        byte_addr;
  logic [7:0]         byte_value;
  logic [4:0]         bit_count;
  logic [14:0]        new_position;
  logic               out_valid;
  logic               out_ready;
  logic signed [31:0] value;
  logic [14:0]        position;
  logic               out_of_range;

  field_reader_sb_t books = new;

  // When steady is set, neither side idles, so the block runs at its full rate.
  bit          steady;
  int          requests_sent;
  int unsigned cycle_count;

  // Byte 0 starts with 110 so that the 31-bit signed read right after it comes out negative.
  bit [7:0] seed_bytes [6] = '{8'hD5, 8'hFF, 8'h00, 8'h80, 8'h7F, 8'h5A};

  msb_first_bit_field_reader dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .mode         (mode),
    .byte_addr    (byte_addr),
    .byte_value   (byte_value),
    .bit_count    (bit_count),
    .new_position (new_position),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .value        (value),
    .position     (position),
    .out_of_range (out_of_range)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Mostly back-to-back, sometimes a few idle cycles, now and then a long pause.
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Presents one request after a random gap and returns at the edge that accepts it.
  // The payload changes only at a falling edge and stays put until the handshake.
  task automatic send_request(bit [2:0] m, bit [11:0] addr, bit [7:0] data,
                              bit [4:0] cnt, bit [14:0] npos);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    mode         <= m;
    byte_addr    <= addr;
    byte_value   <= data;
    bit_count    <= cnt;
    new_position <= npos;
    do @(posedge clk); while (!in_ready);
    books.note_request(m, addr, data, cnt, npos);
    requests_sent++;
  endtask

  // Issues a read at the current cursor. Any byte the read would touch that was never
  // loaded gets a random value first, so no field the block returns uses an unwritten entry.
  // Refused reads touch nothing and need no loads.
  task automatic read_field(bit [2:0] m, bit [4:0] cnt);
    int unsigned start;
    int unsigned len;
    start = books.cursor;
    if (m == MODE_UBITS || m == MODE_SBITS) begin
      len = cnt;
    end else begin
      start = (start + 7) & ~32'd7;
      len   = (m == MODE_UI8) ? 8 : 16;
    end
    if (len != 0 && start + len <= END_BITS) begin
      for (int unsigned b = start >> 3; b <= (start + len - 1) >> 3; b++) begin
        if (!books.loaded[b])
          send_request(MODE_LOAD, 12'(b), 8'($urandom), 5'($urandom), 15'($urandom));
      end
    end
    send_request(m, 12'($urandom), 8'($urandom), cnt, 15'($urandom));
  endtask

  // Random read mode, with the field lengths weighted toward zero, full width and short.
  task automatic random_read();
    int       r;
    bit [4:0] cnt;
    r = $urandom_range(0, 99);
    if (r < 10) cnt = 5'd0;
    else if (r < 20) cnt = 5'd31;
    else if (r < 35) cnt = 5'($urandom_range(1, 8));
    else cnt = 5'($urandom_range(1, 31));
    read_field(3'($urandom_range(MODE_UBITS, MODE_SI16)), cnt);
  endtask

  // Result side: random stalls on out_ready, with the same gap profile as the sender.
  initial begin
    int stall;
    stall     = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
        stall = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) books.check_result(value, position, out_of_range);
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_top: FAIL");
    $finish;
  end

  initial begin
    int pick;
    int first;
    int nbytes;
    int rounds;
    int base_count;
    rst          = 1'b1;
    in_valid     = 1'b0;
    mode         = MODE_LOAD;
    byte_addr    = '0;
    byte_value   = '0;
    bit_count    = '0;
    new_position = '0;
    steady       = 1'b0;
    rounds       = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // A zero-length read straight out of reset touches no byte and leaves the cursor at 0.
    read_field(MODE_UBITS, 5'd0);
    foreach (seed_bytes[i]) send_request(MODE_LOAD, 12'(i), seed_bytes[i], 5'd31, 15'h7fff);
    read_field(MODE_SBITS, 5'd0);
    read_field(MODE_UBITS, 5'd3);
    read_field(MODE_SBITS, 5'd31);
    // Cursor sits at 34 here, so the byte read aligns up to 40 first.
    read_field(MODE_UI8, 5'd0);
    send_request(MODE_SETPOS, 12'd0, 8'd0, 5'd0, 15'd0);
    read_field(MODE_UI16, 5'd0);
    read_field(MODE_SI16, 5'd0);
    send_request(MODE_SPARE, 12'hfff, 8'hff, 5'h1f, 15'h7fff);

    // The last few bytes of the store, then reads that end exactly on the limit and past it.
    send_request(MODE_LOAD, 12'd4092, 8'hFF, 5'd0, 15'd0);
    send_request(MODE_LOAD, 12'd4093, 8'h01, 5'd0, 15'd0);
    send_request(MODE_LOAD, 12'd4094, 8'h80, 5'd0, 15'd0);
    send_request(MODE_LOAD, 12'hfff, 8'hC3, 5'd0, 15'd0);
    send_request(MODE_SETPOS, 12'd0, 8'd0, 5'd0, 15'(END_BITS - 7));
    read_field(MODE_UI8, 5'd0);
    read_field(MODE_UBITS, 5'd7);
    read_field(MODE_UBITS, 5'd1);
    send_request(MODE_SETPOS, 12'd0, 8'd0, 5'd0, 15'h7fff);
    read_field(MODE_SBITS, 5'd0);
    // A refused aligned read must also drop its alignment.
    send_request(MODE_SETPOS, 12'd0, 8'd0, 5'd0, 15'(END_BITS - 14));
    read_field(MODE_SI16, 5'd0);
    send_request(MODE_SETPOS, 12'd0, 8'd0, 5'd0, 15'(END_BITS - 38));
    read_field(MODE_SI16, 5'd0);

    base_count = requests_sent;
    while (requests_sent - base_count < RANDOM_REQUESTS) begin
      if (rounds % 16 == 0) steady = ($urandom_range(0, 4) == 0);
      rounds++;
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        // A record: load a run of bytes, point the cursor into it, read a string of fields.
        // Some records sit against the end of the store so reads run off it.
        first  = (pick < 45) ? $urandom_range(0, ADDR_SPAN - 1)
                             : $urandom_range(ADDR_SPAN - 12, ADDR_SPAN - 1);
        nbytes = $urandom_range(1, 12);
        for (int i = 0; i < nbytes && first + i < ADDR_SPAN; i++)
          send_request(MODE_LOAD, 12'(first + i), 8'($urandom), 5'($urandom), 15'($urandom));
        send_request(MODE_SETPOS, 12'($urandom), 8'($urandom), 5'($urandom),
                     15'(first * 8 + $urandom_range(0, 7)));
        repeat ($urandom_range(2, 8)) random_read();
      end else if (pick < 65) begin
        random_read();
      end else if (pick < 77) begin
        if ($urandom_range(0, 3) == 0)
          send_request(MODE_SETPOS, 12'($urandom), 8'($urandom), 5'($urandom),
                       15'(END_BITS - $urandom_range(0, 40)));
        else
          send_request(MODE_SETPOS, 12'($urandom), 8'($urandom), 5'($urandom), 15'($urandom));
      end else if (pick < 88) begin
        send_request(MODE_LOAD, 12'($urandom), 8'($urandom), 5'($urandom), 15'($urandom));
      end else if (pick < 94) begin
        send_request(MODE_SPARE, 12'($urandom), 8'($urandom), 5'($urandom), 15'($urandom));
      end else begin
        send_request(MODE_SETPOS, 12'($urandom), 8'($urandom), 5'($urandom),
                     15'(END_BITS - $urandom_range(0, 20)));
        random_read();
        random_read();
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (books.pending_fields.size() != 0) @(posedge clk);
    // A stray extra result would show up during this tail wait.
    repeat (TAIL_CYCLES) @(posedge clk);
    if (books.fail_count == 0) $display("tb_top: PASS");
    else $display("tb_top: FAIL");
    $finish;
  end

endmodule
